@@ rtl/telnet_iac_filter_negotiator_unit_macros.svh @@
// Assertion macros used by the Telnet negotiator RTL.
`ifndef TELNET_IAC_FILTER_NEGOTIATOR_UNIT_MACROS_SVH
`define TELNET_IAC_FILTER_NEGOTIATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define TIN_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define TIN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tin_pkg.sv @@
// Types, Telnet codes and the greeting sequence shared by the negotiator modules.
package tin_pkg;

  localparam logic [7:0] TN_IAC  = 8'hFF;
  localparam logic [7:0] TN_DONT = 8'hFE;
  localparam logic [7:0] TN_DO   = 8'hFD;
  localparam logic [7:0] TN_WONT = 8'hFC;
  localparam logic [7:0] TN_WILL = 8'hFB;
  localparam logic [7:0] TN_ECHO = 8'h01;
  localparam logic [7:0] TN_SGA  = 8'h03;

  localparam logic [1:0] CMD_RX      = 2'd0;
  localparam logic [1:0] CMD_SEND    = 2'd1;
  localparam logic [1:0] CMD_CONNECT = 2'd2;

  localparam logic CH_USER = 1'b0;
  localparam logic CH_NET  = 1'b1;

  localparam int HELLO_LEN = 9;
  localparam int IDX_W     = 4;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       channel;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    JOB_USER,
    JOB_NET,
    JOB_REPLY,
    JOB_HELLO
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] verb;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  function automatic logic [7:0] hello_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0, 4'd3, 4'd6: b = TN_IAC;
      4'd1, 4'd4:       b = TN_WILL;
      4'd7:             b = TN_DO;
      4'd2:             b = TN_ECHO;
      4'd5, 4'd8:       b = TN_SGA;
      default:          b = TN_IAC;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/tin_front.sv @@
// Front end: accepts words, runs the IAC parser and option policy, queues jobs.
module tin_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  tin_pkg::item_t    item,
  output logic              item_ready,
  input  tin_pkg::q_status_t q_stat,
  output logic              push,
  output tin_pkg::job_t     job
);

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_IAC,
    PH_VERB
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] pending_verb, pending_verb_next;
  logic       echo_agreed, echo_agreed_next;
  logic       sga_agreed, sga_agreed_next;
  logic       accept;
  logic [7:0] b;

  assign item_ready = !q_stat.full;
  assign accept     = item_valid && item_ready;
  assign b          = item.data_byte;

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    echo_agreed_next  = echo_agreed;
    sga_agreed_next   = sga_agreed;
    push              = 1'b0;
    job.kind          = tin_pkg::JOB_USER;
    job.verb          = pending_verb;
    job.data          = b;
    if (accept) begin
      unique case (item.command)
        tin_pkg::CMD_RX: begin
          unique case (phase)
            PH_NORMAL: begin
              if (b == tin_pkg::TN_IAC) begin
                phase_next = PH_IAC;
              end else begin
                push = 1'b1;
              end
            end
            PH_IAC: begin
              if (b == tin_pkg::TN_IAC) begin
                phase_next = PH_NORMAL;
                push       = 1'b1;
              end else if (b == tin_pkg::TN_WILL || b == tin_pkg::TN_WONT ||
                           b == tin_pkg::TN_DO || b == tin_pkg::TN_DONT) begin
                pending_verb_next = b;
                phase_next        = PH_VERB;
              end else begin
                phase_next = PH_NORMAL;
              end
            end
            PH_VERB: begin
              phase_next = PH_NORMAL;
              job.kind   = tin_pkg::JOB_REPLY;
              if (pending_verb == tin_pkg::TN_DO) begin
                if (b == tin_pkg::TN_ECHO) begin
                  if (!echo_agreed) begin
                    echo_agreed_next = 1'b1;
                    job.verb         = tin_pkg::TN_WILL;
                    push             = 1'b1;
                  end
                end else if (b == tin_pkg::TN_SGA) begin
                  if (!sga_agreed) begin
                    sga_agreed_next = 1'b1;
                    job.verb        = tin_pkg::TN_WILL;
                    push            = 1'b1;
                  end
                end else begin
                  job.verb = tin_pkg::TN_WONT;
                  push     = 1'b1;
                end
              end else if (pending_verb == tin_pkg::TN_WILL) begin
                if (b == tin_pkg::TN_SGA) begin
                  if (!sga_agreed) begin
                    sga_agreed_next = 1'b1;
                    job.verb        = tin_pkg::TN_DO;
                    push            = 1'b1;
                  end
                end else begin
                  job.verb = tin_pkg::TN_DONT;
                  push     = 1'b1;
                end
              end
            end
            default: phase_next = PH_NORMAL;
          endcase
        end
        tin_pkg::CMD_SEND: begin
          job.kind = tin_pkg::JOB_NET;
          push     = 1'b1;
        end
        tin_pkg::CMD_CONNECT: begin
          // A connection starts from a clean parser and no agreed options.
          phase_next        = PH_NORMAL;
          pending_verb_next = 8'h00;
          echo_agreed_next  = 1'b0;
          sga_agreed_next   = 1'b0;
          job.kind          = tin_pkg::JOB_HELLO;
          push              = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NORMAL;
      pending_verb <= 8'h00;
      echo_agreed  <= 1'b0;
      sga_agreed   <= 1'b0;
    end else begin
      phase        <= phase_next;
      pending_verb <= pending_verb_next;
      echo_agreed  <= echo_agreed_next;
      sga_agreed   <= sga_agreed_next;
    end
  end

endmodule

@@ rtl/tin_queue.sv @@
// Small register queue of jobs between the front end and the back end.
module tin_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tin_pkg::job_t      push_job,
  input  logic               pop,
  output tin_pkg::job_t      head,
  output tin_pkg::q_status_t status
);

  // DEPTH must be a power of two so that the pointers wrap on their own.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tin_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/tin_back.sv @@
// Back end: expands each queued job into result words through an output register.
module tin_back (
  input  logic               clk,
  input  logic               rst,
  input  tin_pkg::q_status_t q_stat,
  input  tin_pkg::job_t      q_head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output tin_pkg::result_t   result
);

  logic [tin_pkg::IDX_W-1:0] idx;
  logic                      emit;
  tin_pkg::result_t          word;

  assign emit = q_stat.valid && (!result_valid || result_ready);
  assign pop  = emit && word.last;

  always_comb begin
    word.channel  = tin_pkg::CH_NET;
    word.out_byte = q_head.data;
    word.last     = 1'b1;
    unique case (q_head.kind)
      tin_pkg::JOB_USER: begin
        word.channel = tin_pkg::CH_USER;
      end
      tin_pkg::JOB_NET: begin
        // An outgoing 0xFF is doubled; the second word repeats the same byte.
        word.last = (q_head.data != tin_pkg::TN_IAC) || (idx == tin_pkg::IDX_W'(1));
      end
      tin_pkg::JOB_REPLY: begin
        if (idx == tin_pkg::IDX_W'(0)) begin
          word.out_byte = tin_pkg::TN_IAC;
        end else if (idx == tin_pkg::IDX_W'(1)) begin
          word.out_byte = q_head.verb;
        end
        word.last = (idx == tin_pkg::IDX_W'(2));
      end
      tin_pkg::JOB_HELLO: begin
        word.out_byte = tin_pkg::hello_byte(idx);
        word.last     = (idx == tin_pkg::IDX_W'(tin_pkg::HELLO_LEN - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
        result       <= word;
        idx          <= word.last ? '0 : idx + tin_pkg::IDX_W'(1);
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/telnet_iac_filter_negotiator_unit.sv @@
// Top level of the Telnet IAC filter and option negotiator for one connection.
//
//   Channel  Direction  Handshake                   Word
//   item     in         item_valid / item_ready     command, data_byte
//   result   out        result_valid / result_ready channel, out_byte, last
//
// A word is taken every cycle while the job queue has room; its job's results
// pass through the output register. The back end emits one result per cycle
// unless result_ready stalls it, so a job yields 1, 2, 3 or 9 words (user byte,
// escaped 0xFF, option reply, greeting). rst is synchronous and clears parser,
// flags, queue and result_valid; a stall backs up the queue of QUEUE_DEPTH jobs.
`include "telnet_iac_filter_negotiator_unit_macros.svh"

module telnet_iac_filter_negotiator_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  tin_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output tin_pkg::result_t result
);

  tin_pkg::q_status_t q_stat;
  tin_pkg::job_t      push_job;
  tin_pkg::job_t      q_head;
  logic               q_push;
  logic               q_pop;

  tin_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .q_stat     (q_stat),
    .push       (q_push),
    .job        (push_job)
  );

  tin_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_stat)
  );

  tin_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_head       (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `TIN_ASSERT_IMPLIES(a_empty_ready, !q_stat.valid, item_ready, "empty queue must accept")
  `TIN_ASSERT_IMPLIES(a_pop_nonempty, q_pop, q_stat.valid, "pop from empty queue")
  `TIN_ASSERT_IMPLIES(a_push_on_accept, q_push, item_valid && item_ready, "push without accept")
  `TIN_ASSERT_NEXT(a_connect_queued, item_valid && item_ready && item.command == tin_pkg::CMD_CONNECT, q_stat.valid, "connect left no job")

endmodule

@@ tb/telnet_iac_filter_negotiator_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Telnet IAC filter and option negotiator.
module telnet_iac_filter_negotiator_unit_test;

  // Command code with no meaning; the block must ignore such a word.
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         LONG_HOLD   = 300;
  localparam int         IDLE_LIMIT  = 5000;
  localparam int         TAIL_CYCLES = 20;
  localparam logic [71:0] GREETING = {tin_pkg::TN_IAC, tin_pkg::TN_WILL, tin_pkg::TN_ECHO,
                                      tin_pkg::TN_IAC, tin_pkg::TN_WILL, tin_pkg::TN_SGA,
                                      tin_pkg::TN_IAC, tin_pkg::TN_DO,   tin_pkg::TN_SGA};

  typedef enum logic [1:0] {
    RX_DATA,
    RX_AFTER_IAC,
    RX_AFTER_VERB
  } rx_phase_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  tin_pkg::item_t   item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  tin_pkg::result_t result;

  tin_pkg::item_t   pending_words[$];
  tin_pkg::result_t due_out[$];

  // Mirror of the connection state.
  rx_phase_t  rx_phase  = RX_DATA;
  logic [7:0] held_verb = '0;
  logic       echo_on   = 1'b0;
  logic       sga_on    = 1'b0;

  int   send_gap_pct   = 0;
  int   sink_stall_pct = 0;
  logic hold_output    = 1'b0;
  int   hold_count     = 0;
  int   idle_cycles    = 0;
  int   errors         = 0;
  int   words_in       = 0;
  int   words_out      = 0;
  int   connects       = 0;

  telnet_iac_filter_negotiator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the words that one accepted input word must produce.
  function automatic void answer_word(tin_pkg::item_t w);
    tin_pkg::result_t burst[$];
    logic [7:0]       b;
    logic [7:0]       verb;
    logic             reply;
    b     = w.data_byte;
    verb  = '0;
    reply = 1'b0;
    case (w.command)
      tin_pkg::CMD_RX: begin
        case (rx_phase)
          RX_DATA: begin
            if (b == tin_pkg::TN_IAC) rx_phase = RX_AFTER_IAC;
            else burst.push_back('{channel: tin_pkg::CH_USER, out_byte: b, last: 1'b0});
          end
          RX_AFTER_IAC: begin
            if (b == tin_pkg::TN_IAC) begin
              rx_phase = RX_DATA;
              burst.push_back('{channel: tin_pkg::CH_USER, out_byte: tin_pkg::TN_IAC,
                                last: 1'b0});
            end else if (b == tin_pkg::TN_WILL || b == tin_pkg::TN_WONT ||
                         b == tin_pkg::TN_DO || b == tin_pkg::TN_DONT) begin
              held_verb = b;
              rx_phase  = RX_AFTER_VERB;
            end else begin
              rx_phase = RX_DATA;
            end
          end
          RX_AFTER_VERB: begin
            rx_phase = RX_DATA;
            if (held_verb == tin_pkg::TN_DO) begin
              if (b == tin_pkg::TN_ECHO) begin
                if (!echo_on) begin
                  echo_on = 1'b1;
                  reply   = 1'b1;
                  verb    = tin_pkg::TN_WILL;
                end
              end else if (b == tin_pkg::TN_SGA) begin
                if (!sga_on) begin
                  sga_on = 1'b1;
                  reply  = 1'b1;
                  verb   = tin_pkg::TN_WILL;
                end
              end else begin
                reply = 1'b1;
                verb  = tin_pkg::TN_WONT;
              end
            end else if (held_verb == tin_pkg::TN_WILL) begin
              if (b == tin_pkg::TN_SGA) begin
                if (!sga_on) begin
                  sga_on = 1'b1;
                  reply  = 1'b1;
                  verb   = tin_pkg::TN_DO;
                end
              end else begin
                reply = 1'b1;
                verb  = tin_pkg::TN_DONT;
              end
            end
            if (reply) begin
              burst.push_back('{channel: tin_pkg::CH_NET, out_byte: tin_pkg::TN_IAC,
                                last: 1'b0});
              burst.push_back('{channel: tin_pkg::CH_NET, out_byte: verb, last: 1'b0});
              burst.push_back('{channel: tin_pkg::CH_NET, out_byte: b, last: 1'b0});
            end
          end
          default: rx_phase = RX_DATA;
        endcase
      end
      tin_pkg::CMD_SEND: begin
        burst.push_back('{channel: tin_pkg::CH_NET, out_byte: b, last: 1'b0});
        if (b == tin_pkg::TN_IAC) begin
          burst.push_back('{channel: tin_pkg::CH_NET, out_byte: tin_pkg::TN_IAC,
                            last: 1'b0});
        end
      end
      tin_pkg::CMD_CONNECT: begin
        rx_phase  = RX_DATA;
        held_verb = '0;
        echo_on   = 1'b0;
        sga_on    = 1'b0;
        connects++;
        for (int i = 0; i < tin_pkg::HELLO_LEN; i++) begin
          burst.push_back('{channel: tin_pkg::CH_NET, out_byte: GREETING[71 - 8 * i -: 8],
                            last: 1'b0});
        end
      end
      default: ;
    endcase
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) due_out.push_back(burst[i]);
  endfunction

  task automatic queue_word(input logic [1:0] cmd, input logic [7:0] b);
    pending_words.push_back('{command: cmd, data_byte: b});
  endtask

  task automatic queue_option(input logic [7:0] verb, input logic [7:0] opt);
    queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
    queue_word(tin_pkg::CMD_RX, verb);
    queue_word(tin_pkg::CMD_RX, opt);
  endtask

  // Mostly well-formed Telnet traffic with random content, plus some noise.
  task automatic add_random_traffic(input int n);
    int         added;
    int         roll;
    int         sel;
    logic [7:0] opt;
    added = 0;
    while (added < n) begin
      roll = $urandom_range(99);
      if (roll < 28) begin
        queue_word(tin_pkg::CMD_RX, 8'($urandom_range(254)));
        added += 1;
      end else if (roll < 36) begin
        queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
        queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
        added += 2;
      end else if (roll < 60) begin
        sel = $urandom_range(9);
        if (sel < 4) opt = tin_pkg::TN_ECHO;
        else if (sel < 7) opt = tin_pkg::TN_SGA;
        else opt = 8'($urandom);
        queue_option(8'(tin_pkg::TN_WILL + $urandom_range(3)), opt);
        added += 3;
      end else if (roll < 64) begin
        // IAC followed by a command byte that is not a verb.
        queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
        queue_word(tin_pkg::CMD_RX, 8'($urandom_range(250)));
        added += 2;
      end else if (roll < 84) begin
        if ($urandom_range(3) == 0) queue_word(tin_pkg::CMD_SEND, tin_pkg::TN_IAC);
        else queue_word(tin_pkg::CMD_SEND, 8'($urandom));
        added += 1;
      end else if (roll < 87) begin
        queue_word(tin_pkg::CMD_CONNECT, 8'($urandom));
        added += 1;
      end else if (roll < 89) begin
        queue_word(CMD_SPARE, 8'($urandom));
      end else if (roll < 94) begin
        // A sequence cut short after its verb; whatever comes next finishes it.
        queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
        queue_word(tin_pkg::CMD_RX, 8'(tin_pkg::TN_WILL + $urandom_range(3)));
        added += 2;
      end else begin
        queue_word(tin_pkg::CMD_RX, 8'($urandom));
        added += 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || item_valid || due_out.size() != 0) @(negedge clk);
  endtask

  // Sender: offers the next pending word, holding it until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item       <= '0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) begin
        answer_word(item);
        words_in++;
      end
      if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        item       <= pending_words.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each word taken and decides the next ready.
  always @(posedge clk) begin
    tin_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      hold_count   <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_out.size() == 0) begin
          $error("word with none due: channel %0d, out_byte %02h, last %0d",
                 result.channel, result.out_byte, result.last);
          errors++;
        end else begin
          want = due_out.pop_front();
          words_out++;
          if (result.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, result.channel);
            errors++;
          end
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            errors++;
          end
        end
      end
      if (hold_output && hold_count < LONG_HOLD) begin
        result_ready <= 1'b0;
        hold_count   <= hold_count + 1;
      end else begin
        if (!hold_output) hold_count <= 0;
        result_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: only counts while something is still owed.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (pending_words.size() == 0 && !item_valid && due_out.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d words still due",
                 IDLE_LIMIT, due_out.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    queue_word(tin_pkg::CMD_CONNECT, 8'hA5);
    queue_word(tin_pkg::CMD_RX, 8'hFE);
    queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
    queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
    queue_word(tin_pkg::CMD_SEND, tin_pkg::TN_IAC);
    queue_word(tin_pkg::CMD_SEND, 8'h00);
    queue_option(tin_pkg::TN_DO, tin_pkg::TN_ECHO);
    queue_option(tin_pkg::TN_DO, tin_pkg::TN_ECHO);
    queue_option(tin_pkg::TN_WILL, tin_pkg::TN_SGA);
    queue_option(tin_pkg::TN_DO, tin_pkg::TN_SGA);
    queue_option(tin_pkg::TN_WILL, tin_pkg::TN_ECHO);
    queue_option(tin_pkg::TN_WONT, tin_pkg::TN_ECHO);
    queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
    queue_word(tin_pkg::CMD_RX, 8'hF1);
    queue_word(CMD_SPARE, 8'hFF);
    // A connect right after an IAC must reset the parser.
    queue_word(tin_pkg::CMD_RX, tin_pkg::TN_IAC);
    queue_word(tin_pkg::CMD_CONNECT, 8'h00);
    wait_drained();

    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 61; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 61; end
        default: begin send_gap_pct = 7; sink_stall_pct = 7; end
      endcase
      add_random_traffic(98);
      wait_drained();
    end

    // Hold the output off for a long stretch while words keep coming.
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    hold_output    = 1'b1;
    add_random_traffic(40);
    while (hold_count < LONG_HOLD) @(negedge clk);
    hold_output = 1'b0;
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_out.size() != 0) begin
      $error("%0d words still due at the end", due_out.size());
      errors++;
    end
    $display("Sent %0d input words (%0d connects) and checked %0d output words.",
             words_in, connects, words_out);
    $display("Phases: no gaps, sender gaps, output stalls, light gaps both ways, long hold.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
